// File: rtl/gsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gsc_pkg;

  // Default number of glyph slots.
  localparam int SLOTS_DEF = 124;

  // Field widths.
  localparam int CODE_W   = 14;
  localparam int TAG_W    = 13;
  localparam int AGE_W    = 2;
  localparam int SLOT_W   = 7;
  localparam int OFFSET_W = 20;
  localparam int BYTES_W  = 8;

  // Bits of the match and free vectors handled by one leaf of the encoder tree.
  localparam int GRP_W  = 16;
  localparam int GRP_IW = 4;

  // Request codes.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Age written on a hit or an allocation.
  localparam logic [AGE_W-1:0] FRESH_AGE = 2'd2;

  // Fill sizes in bytes.
  localparam logic [BYTES_W-1:0] NARROW_BYTES = 8'h60;
  localparam logic [BYTES_W-1:0] WIDE_BYTES   = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_ENC1,
    ST_ENC2,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_key;
    logic tick;
    logic cmp_en;
    logic enc1_en;
    logic enc2_en;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/gsc_store.sv
`timescale 1ns / 1ps
`default_nettype none

module gsc_store #(
  parameter int SLOTS = gsc_pkg::SLOTS_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  gsc_pkg::cmd_t                  cmd,
  input  wire [gsc_pkg::TAG_W-1:0]       key_tag,
  input  wire                            key_wide,
  input  wire                            hit_any,
  input  wire [$clog2(SLOTS)-1:0]        hit_idx,
  input  wire                            free_any,
  input  wire [$clog2(SLOTS)-1:0]        free_idx,
  output logic [SLOTS-1:0]               match_vec,
  output logic [SLOTS-1:0]               free_vec
);

  localparam int IW = $clog2(SLOTS);

  logic [gsc_pkg::TAG_W-1:0] tag [SLOTS];
  logic [gsc_pkg::AGE_W-1:0] age [SLOTS];
  logic [SLOTS-1:0]          vld;

  logic [SLOTS-1:0] eq;
  logic [SLOTS-1:0] zr;
  logic [SLOTS-1:0] sel;
  logic [IW-1:0]    base;
  logic [IW:0]      base_up;
  logic             do_wr;
  logic             alloc;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      eq[i] = vld[i] && (tag[i] == key_tag);
      zr[i] = (age[i] == '0);
    end
  end

  // A pair starting at slot i needs slot i+1 too; the top slot never starts a pair.
  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      match_vec <= key_wide ? (eq & (eq >> 1)) : eq;
      free_vec  <= key_wide ? (zr & (zr >> 1)) : zr;
    end
  end

  always_comb begin
    base    = hit_any ? hit_idx : free_idx;
    base_up = {1'b0, base} + (IW+1)'(1);
    do_wr   = cmd.commit && (hit_any || free_any);
    alloc   = cmd.commit && !hit_any && free_any;
    for (int i = 0; i < SLOTS; i++) begin
      sel[i] = (IW'(i) == base) || (key_wide && ((IW+1)'(i) == base_up));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        age[i] <= '0;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (cmd.tick) begin
          if (age[i] != '0) begin
            age[i] <= age[i] - gsc_pkg::AGE_W'(1);
          end
        end else if (do_wr && sel[i]) begin
          age[i] <= gsc_pkg::FRESH_AGE;
        end
        if (alloc && sel[i]) begin
          vld[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (alloc && sel[i]) begin
        tag[i] <= key_tag;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/gsc_enc.sv
`timescale 1ns / 1ps
`default_nettype none

module gsc_enc #(
  parameter int SLOTS = gsc_pkg::SLOTS_DEF
) (
  input  wire                     clk,
  input  gsc_pkg::cmd_t           cmd,
  input  wire [SLOTS-1:0]         match_vec,
  input  wire [SLOTS-1:0]         free_vec,
  output logic                    hit_any,
  output logic [$clog2(SLOTS)-1:0] hit_idx,
  output logic                    free_any,
  output logic [$clog2(SLOTS)-1:0] free_idx
);

  localparam int IW   = $clog2(SLOTS);
  localparam int GW   = gsc_pkg::GRP_W;
  localparam int NG   = (SLOTS + GW - 1) / GW;
  localparam int GIW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int PADW = NG * GW;

  logic [PADW-1:0] m_pad;
  logic [PADW-1:0] f_pad;

  logic [gsc_pkg::GRP_IW-1:0] lo_next [NG];
  logic [gsc_pkg::GRP_IW-1:0] hi_next [NG];
  logic [NG-1:0]              m_any_next;
  logic [NG-1:0]              f_any_next;

  logic [gsc_pkg::GRP_IW-1:0] grp_lo [NG];
  logic [gsc_pkg::GRP_IW-1:0] grp_hi [NG];
  logic [NG-1:0]              grp_m;
  logic [NG-1:0]              grp_f;

  logic [GIW-1:0]             g_lo;
  logic [GIW-1:0]             g_hi;
  logic [gsc_pkg::GRP_IW-1:0] b_lo;
  logic [gsc_pkg::GRP_IW-1:0] b_hi;
  logic [GIW+gsc_pkg::GRP_IW-1:0] full_lo;
  logic [GIW+gsc_pkg::GRP_IW-1:0] full_hi;

  assign m_pad = PADW'(match_vec);
  assign f_pad = PADW'(free_vec);

  // First level: lowest match and highest free slot inside each group.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      lo_next[g]    = '0;
      hi_next[g]    = '0;
      m_any_next[g] = |m_pad[g*GW +: GW];
      f_any_next[g] = |f_pad[g*GW +: GW];
      for (int b = GW - 1; b >= 0; b--) begin
        if (m_pad[g*GW + b]) begin
          lo_next[g] = gsc_pkg::GRP_IW'(b);
        end
      end
      for (int b = 0; b < GW; b++) begin
        if (f_pad[g*GW + b]) begin
          hi_next[g] = gsc_pkg::GRP_IW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enc1_en) begin
      for (int g = 0; g < NG; g++) begin
        grp_lo[g] <= lo_next[g];
        grp_hi[g] <= hi_next[g];
      end
      grp_m <= m_any_next;
      grp_f <= f_any_next;
    end
  end

  // Second level: lowest group holding a match, highest group holding a free slot.
  always_comb begin
    g_lo = '0;
    g_hi = '0;
    b_lo = '0;
    b_hi = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_m[g]) begin
        g_lo = GIW'(g);
        b_lo = grp_lo[g];
      end
    end
    for (int g = 0; g < NG; g++) begin
      if (grp_f[g]) begin
        g_hi = GIW'(g);
        b_hi = grp_hi[g];
      end
    end
    full_lo = {g_lo, b_lo};
    full_hi = {g_hi, b_hi};
  end

  always_ff @(posedge clk) begin
    if (cmd.enc2_en) begin
      hit_any  <= |grp_m;
      free_any <= |grp_f;
      hit_idx  <= full_lo[IW-1:0];
      free_idx <= full_hi[IW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/gsc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module gsc_dp #(
  parameter int SLOTS = gsc_pkg::SLOTS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  gsc_pkg::cmd_t                   cmd,
  input  wire [gsc_pkg::CODE_W-1:0]       codepoint,
  output logic [gsc_pkg::SLOT_W-1:0]      slot,
  output logic                            hit,
  output logic                            fill,
  output logic                            fallback,
  output logic                            font_select,
  output logic [gsc_pkg::OFFSET_W-1:0]    rom_offset,
  output logic [gsc_pkg::BYTES_W-1:0]     fill_bytes
);

  localparam int IW = $clog2(SLOTS);

  logic [gsc_pkg::CODE_W-1:0] key;
  logic [gsc_pkg::TAG_W-1:0]  key_tag;
  logic                       key_wide;

  logic [SLOTS-1:0] match_vec;
  logic [SLOTS-1:0] free_vec;
  logic             hit_any;
  logic             free_any;
  logic [IW-1:0]    hit_idx;
  logic [IW-1:0]    free_idx;

  logic [gsc_pkg::OFFSET_W-1:0] off_narrow;
  logic [gsc_pkg::OFFSET_W-1:0] off_wide;

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key <= codepoint;
    end
  end

  assign key_tag  = key[gsc_pkg::CODE_W-1:1];
  assign key_wide = key[gsc_pkg::CODE_W-1];

  gsc_store #(.SLOTS(SLOTS)) u_store (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .key_tag   (key_tag),
    .key_wide  (key_wide),
    .hit_any   (hit_any),
    .hit_idx   (hit_idx),
    .free_any  (free_any),
    .free_idx  (free_idx),
    .match_vec (match_vec),
    .free_vec  (free_vec)
  );

  gsc_enc #(.SLOTS(SLOTS)) u_enc (
    .clk       (clk),
    .cmd       (cmd),
    .match_vec (match_vec),
    .free_vec  (free_vec),
    .hit_any   (hit_any),
    .hit_idx   (hit_idx),
    .free_any  (free_any),
    .free_idx  (free_idx)
  );

  // Narrow glyphs are 96 bytes each; wide glyphs are 128 bytes, indexed without the wide bit.
  assign off_narrow = gsc_pkg::OFFSET_W'(key_tag) * gsc_pkg::OFFSET_W'(gsc_pkg::NARROW_BYTES);
  assign off_wide   = gsc_pkg::OFFSET_W'({key[gsc_pkg::CODE_W-2:1], 7'b0});

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (hit_any) begin
        slot        <= gsc_pkg::SLOT_W'(hit_idx);
        hit         <= 1'b1;
        fill        <= 1'b0;
        fallback    <= 1'b0;
        font_select <= 1'b0;
        rom_offset  <= '0;
        fill_bytes  <= '0;
      end else if (free_any) begin
        slot        <= gsc_pkg::SLOT_W'(free_idx);
        hit         <= 1'b0;
        fill        <= 1'b1;
        fallback    <= 1'b0;
        font_select <= key_wide;
        rom_offset  <= key_wide ? off_wide : off_narrow;
        fill_bytes  <= key_wide ? gsc_pkg::WIDE_BYTES : gsc_pkg::NARROW_BYTES;
      end else begin
        slot        <= '0;
        hit         <= 1'b0;
        fill        <= 1'b0;
        fallback    <= 1'b1;
        font_select <= 1'b0;
        rom_offset  <= '0;
        fill_bytes  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/gsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module gsc_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  output logic           req_ready,
  input  wire            req_type,
  output logic           rsp_valid,
  input  wire            rsp_ready,
  output gsc_pkg::cmd_t  cmd
);

  gsc_pkg::state_t state;
  gsc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gsc_pkg::ST_IDLE: begin
        if (req_valid && req_type == gsc_pkg::REQ_LOOKUP) begin
          state_next = gsc_pkg::ST_CMP;
        end
      end
      gsc_pkg::ST_CMP:  state_next = gsc_pkg::ST_ENC1;
      gsc_pkg::ST_ENC1: state_next = gsc_pkg::ST_ENC2;
      gsc_pkg::ST_ENC2: state_next = gsc_pkg::ST_DONE;
      gsc_pkg::ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = gsc_pkg::ST_IDLE;
        end
      end
      default: state_next = gsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      gsc_pkg::ST_IDLE: begin
        req_ready    = 1'b1;
        cmd.tick     = req_valid && req_type == gsc_pkg::REQ_TICK;
        cmd.load_key = req_valid && req_type == gsc_pkg::REQ_LOOKUP;
      end
      gsc_pkg::ST_CMP:  cmd.cmp_en  = 1'b1;
      gsc_pkg::ST_ENC1: cmd.enc1_en = 1'b1;
      gsc_pkg::ST_ENC2: cmd.enc2_en = 1'b1;
      gsc_pkg::ST_DONE: cmd.commit  = !rsp_valid || rsp_ready;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/glyph_slot_cache_ttl.sv
`timescale 1ns / 1ps
`default_nettype none

// Glyph slot cache with time-to-live aging. Each of SLOTS slots holds a tag
// (the glyph code shifted right by one) and a 2-bit age. A lookup request
// returns exactly one result: the lowest slot (or adjacent pair, for a wide
// glyph with bit 13 set) whose tag matches is a hit and is refreshed to age 2;
// otherwise the highest slot or pair whose ages are all zero is tagged and a
// fill request is reported with the font region, ROM byte offset and byte
// count; if nothing is free the result is a fallback to slot 0 and the cache
// is left unchanged. A tick request decrements every nonzero age and returns
// no result. A lookup occupies the block from the input transfer to the
// result landing in the output register, in order: taking the code, the
// parallel tag and age compare across all slots, the two levels of the
// priority encoder, and last updating the slot state and loading the
// result. A tick completes in the cycle it is accepted. The
// result register lets the next request be accepted while a result still
// waits for its output transfer; a lookup that finishes before that transfer
// holds in its last cycle until the register frees up. After reset all slots
// are empty and all ages are zero, with no startup delay.

module glyph_slot_cache_ttl #(
  parameter int SLOTS = gsc_pkg::SLOTS_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            req_valid,
  output logic                           req_ready,
  input  wire                            req_type,
  input  wire [gsc_pkg::CODE_W-1:0]      codepoint,
  output logic                           rsp_valid,
  input  wire                            rsp_ready,
  output logic [gsc_pkg::SLOT_W-1:0]     slot,
  output logic                           hit,
  output logic                           fill,
  output logic                           fallback,
  output logic                           font_select,
  output logic [gsc_pkg::OFFSET_W-1:0]   rom_offset,
  output logic [gsc_pkg::BYTES_W-1:0]    fill_bytes
);

  gsc_pkg::cmd_t cmd;

  // The controller sequences the lookup and owns both handshakes.
  gsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_type  (req_type),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  // The datapath holds the slot state, the compare and encode logic, and the
  // result register.
  gsc_dp #(.SLOTS(SLOTS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .codepoint   (codepoint),
    .slot        (slot),
    .hit         (hit),
    .fill        (fill),
    .fallback    (fallback),
    .font_select (font_select),
    .rom_offset  (rom_offset),
    .fill_bytes  (fill_bytes)
  );

endmodule

`default_nettype wire

// File: test/glyph_cache_mirror_pkg.sv
`timescale 1ns / 1ps

package glyph_cache_mirror_pkg;

  import gsc_pkg::*;

  // One lookup reply, with the widths of the output ports.
  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                hit;
    logic                fill;
    logic                fallback;
    logic                font_select;
    logic [OFFSET_W-1:0] rom_offset;
    logic [BYTES_W-1:0]  fill_bytes;
  } glyph_reply_t;

  // Mirror of the slot tags and ages. It predicts the reply of every accepted lookup
  // and holds those replies until the block returns them.
  class slot_cache_mirror;
    logic [CODE_W-1:0] tag_of[SLOTS_DEF];
    logic [AGE_W-1:0]  age_of[SLOTS_DEF];
    glyph_reply_t      awaited[$];
    int unsigned       errors;
    int unsigned       lookups;
    int unsigned       ticks;
    int unsigned       hits;
    int unsigned       fills;
    int unsigned       wide_fills;
    int unsigned       fallbacks;

    function new();
      foreach (tag_of[i]) begin
        tag_of[i] = '1;
        age_of[i] = '0;
      end
      errors     = 0;
      lookups    = 0;
      ticks      = 0;
      hits       = 0;
      fills      = 0;
      wide_fills = 0;
      fallbacks  = 0;
    endfunction

    function void note_request(logic kind, logic [CODE_W-1:0] code);
      logic              wide;
      logic [CODE_W-1:0] tag;
      int                found;
      int                spare;
      glyph_reply_t      r;
      wide  = code[CODE_W-1];
      tag   = code >> 1;
      found = -1;
      spare = -1;
      r     = '0;
      if (kind == REQ_TICK) begin
        ticks++;
        foreach (age_of[i]) begin
          if (age_of[i] != 0) age_of[i] = age_of[i] - 1'b1;
        end
        return;
      end
      lookups++;
      for (int i = 0; i < SLOTS_DEF; i++) begin
        if (!wide) begin
          if (tag_of[i] == tag) begin
            found = i;
            break;
          end
          if (age_of[i] == 0) spare = i;
        end else if (i + 1 < SLOTS_DEF) begin
          // The pair bound is tested before the second slot is looked at.
          if (tag_of[i] == tag && tag_of[i+1] == tag) begin
            found = i;
            break;
          end
          if (age_of[i] == 0 && age_of[i+1] == 0) spare = i;
        end
      end
      if (found >= 0) begin
        hits++;
        age_of[found] = FRESH_AGE;
        if (wide) age_of[found+1] = FRESH_AGE;
        r.slot = SLOT_W'(found);
        r.hit  = 1'b1;
      end else if (spare >= 0) begin
        fills++;
        age_of[spare] = FRESH_AGE;
        tag_of[spare] = tag;
        r.slot = SLOT_W'(spare);
        r.fill = 1'b1;
        if (wide) begin
          wide_fills++;
          age_of[spare+1] = FRESH_AGE;
          tag_of[spare+1] = tag;
          r.font_select = 1'b1;
          r.rom_offset  = OFFSET_W'(code[CODE_W-2:1]) * OFFSET_W'(WIDE_BYTES);
          r.fill_bytes  = WIDE_BYTES;
        end else begin
          r.rom_offset = OFFSET_W'(code >> 1) * OFFSET_W'(NARROW_BYTES);
          r.fill_bytes = NARROW_BYTES;
        end
      end else begin
        // Nothing free: fall back to slot 0 and leave the cache alone.
        fallbacks++;
        r.fallback = 1'b1;
      end
      awaited.push_back(r);
    endfunction

    function void check_reply(glyph_reply_t got);
      glyph_reply_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: reply with none outstanding: slot %0d hit %0b fill %0b fallback %0b",
                 $time, got.slot, got.hit, got.fill, got.fallback);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 20) begin
          if (got.slot !== want.slot)
            $display("%0t: slot expected %0d, got %0d", $time, want.slot, got.slot);
          if (got.hit !== want.hit)
            $display("%0t: hit expected %0b, got %0b", $time, want.hit, got.hit);
          if (got.fill !== want.fill)
            $display("%0t: fill expected %0b, got %0b", $time, want.fill, got.fill);
          if (got.fallback !== want.fallback)
            $display("%0t: fallback expected %0b, got %0b", $time, want.fallback,
                     got.fallback);
          if (got.font_select !== want.font_select)
            $display("%0t: font_select expected %0b, got %0b", $time, want.font_select,
                     got.font_select);
          if (got.rom_offset !== want.rom_offset)
            $display("%0t: rom_offset expected %0d, got %0d", $time, want.rom_offset,
                     got.rom_offset);
          if (got.fill_bytes !== want.fill_bytes)
            $display("%0t: fill_bytes expected %0d, got %0d", $time, want.fill_bytes,
                     got.fill_bytes);
        end
      end
    endfunction
  endclass

endpackage

// File: test/glyph_slot_cache_ttl_tb.sv
`timescale 1ns / 1ps

// Testbench for the glyph slot cache. A sender drives lookups and age ticks,
// a receiver takes the replies, and a mirror of the cache predicts every
// reply at the moment its lookup is transferred. Replies are compared in
// order, field by field.
module glyph_slot_cache_ttl_tb;

  import gsc_pkg::*;
  import glyph_cache_mirror_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 7;
  // Generous bound on cycles with no transfer on either side. The longest
  // legal quiet stretch is the deliberate receiver hold-off.
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 330;
  // Time to let the block finish any lookup still in flight before the final check.
  localparam int SETTLE_CYCLES   = 20;
  localparam int RECENT_DEPTH    = 32;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                req_valid   = 1'b0;
  logic                req_ready;
  logic                req_type    = REQ_LOOKUP;
  logic [CODE_W-1:0]   codepoint   = '0;
  logic                rsp_valid;
  logic                rsp_ready   = 1'b0;
  logic [SLOT_W-1:0]   slot;
  logic                hit;
  logic                fill;
  logic                fallback;
  logic                font_select;
  logic [OFFSET_W-1:0] rom_offset;
  logic [BYTES_W-1:0]  fill_bytes;

  // Idling knobs, in percent of cycles, set per phase by the stimulus.
  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  // The stimulus raises this to ask the receiver for one long hold-off.
  bit          hold_request  = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  // Codes looked up lately. Reusing them is what produces hits.
  logic [CODE_W-1:0] recent_codes[RECENT_DEPTH];
  int unsigned       recent_n  = 0;
  int unsigned       recent_wr = 0;

  slot_cache_mirror mirror = new();

  glyph_slot_cache_ttl i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_type   (req_type),
    .codepoint  (codepoint),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .slot       (slot),
    .hit        (hit),
    .fill       (fill),
    .fallback   (fallback),
    .font_select(font_select),
    .rom_offset (rom_offset),
    .fill_bytes (fill_bytes)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Offer one request and return at the edge where it is transferred. All
  // sampling happens right after the edge, so it sees the values that the
  // edge itself saw. Valid is only lowered when an idle gap is taken, which
  // keeps back-to-back requests from toggling it within one time step.
  task automatic send_request(input logic kind, input logic [CODE_W-1:0] code);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= kind;
    codepoint <= code;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    mirror.note_request(kind, code);
    if (kind == REQ_LOOKUP) begin
      recent_codes[recent_wr] = code;
      recent_wr = (recent_wr + 1) % RECENT_DEPTH;
      if (recent_n < RECENT_DEPTH) recent_n++;
    end
  endtask

  // Stop offering and wait for every outstanding reply. The extra edge
  // keeps valid from being lowered and raised again in one time step.
  task automatic drain_replies();
    req_valid <= 1'b0;
    @(posedge clk);
    while (mirror.awaited.size() != 0) @(posedge clk);
  endtask

  // Receiver: checks each transferred reply, then decides whether to stall
  // in the next cycle. A requested hold-off is counted down here.
  always @(posedge clk) begin
    glyph_reply_t seen;
    if (!rst && rsp_valid && rsp_ready) begin
      seen.slot        = slot;
      seen.hit         = hit;
      seen.fill        = fill;
      seen.fallback    = fallback;
      seen.font_select = font_select;
      seen.rom_offset  = rom_offset;
      seen.fill_bytes  = fill_bytes;
      mirror.check_reply(seen);
    end
    if (hold_request) begin
      hold_left    = HOLD_OFF_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Watchdog: a run that stops making transfers is a failure.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d replies outstanding", $time,
                 quiet_cycles, mirror.awaited.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int unsigned       sent;
    int unsigned       burst;
    int unsigned       tick_pct;
    int unsigned       pick;
    logic              kind;
    logic [CODE_W-1:0] code;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part. From an empty cache the first wide glyph must land on
    // the pair just below the top, since a pair may not start at the last
    // slot. Then the code extremes, hits on both widths, a hit through the
    // low code bit that the tag drops, two ticks that age everything out, a
    // hit on a stale tag, reuse of aged-out slots, and narrow and wide codes
    // whose low 13 bits agree but whose tags must differ.
    send_request(REQ_LOOKUP, 14'h2000);
    send_request(REQ_LOOKUP, 14'h0000);
    send_request(REQ_LOOKUP, 14'h1fff);
    send_request(REQ_LOOKUP, 14'h3fff);
    send_request(REQ_LOOKUP, 14'h0000);
    send_request(REQ_LOOKUP, 14'h0001);
    send_request(REQ_LOOKUP, 14'h3ffe);
    send_request(REQ_LOOKUP, 14'h2001);
    send_request(REQ_TICK,   14'h3fff);
    send_request(REQ_TICK,   14'h0000);
    send_request(REQ_LOOKUP, 14'h3fff);
    send_request(REQ_LOOKUP, 14'h1555);
    send_request(REQ_LOOKUP, 14'h2aaa);
    send_request(REQ_LOOKUP, 14'h0aaa);
    send_request(REQ_LOOKUP, 14'h3555);
    send_request(REQ_TICK,   14'h1555);
    send_request(REQ_LOOKUP, 14'h2aab);
    send_request(REQ_LOOKUP, 14'h1fff);
    drain_replies();

    // Random part in four phases: no idling, a mostly idle sender, a mostly
    // stalling receiver, and light idling on both sides. Each phase is made
    // of bursts with different tick rates. A burst with no ticks fills the
    // cache until lookups fall back; bursts with many ticks free slots again.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          rsp_stall_pct = 0;
          // The receiver holds off while the sender keeps offering, so the
          // block fills its result register and stops taking requests.
          hold_request = 1'b1;
        end
        1: begin
          send_idle_pct = 81;
          rsp_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          rsp_stall_pct = 81;
        end
        default: begin
          send_idle_pct = 8;
          rsp_stall_pct = 8;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        case ($urandom_range(3))
          0: begin
            burst    = 150;
            tick_pct = 0;
          end
          1: begin
            burst    = $urandom_range(30, 90);
            tick_pct = 5;
          end
          2: begin
            burst    = $urandom_range(30, 90);
            tick_pct = 15;
          end
          default: begin
            burst    = $urandom_range(30, 90);
            tick_pct = 35;
          end
        endcase
        repeat (burst) begin
          pick = $urandom_range(99);
          kind = ($urandom_range(99) < tick_pct) ? REQ_TICK : REQ_LOOKUP;
          if (kind == REQ_LOOKUP && recent_n != 0 && pick < 45) begin
            code = recent_codes[$urandom_range(recent_n - 1)];
          end else if (kind == REQ_LOOKUP && recent_n != 0 && pick < 55) begin
            // Same tag through the dropped low bit.
            code = recent_codes[$urandom_range(recent_n - 1)] ^ 14'h0001;
          end else begin
            code = CODE_W'($urandom_range(16383));
          end
          send_request(kind, code);
        end
        sent += burst;
      end
      // The sender waits here until every reply of the phase has come.
      drain_replies();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.awaited.size() != 0) begin
      mirror.errors++;
      $display("%0t: %0d replies never arrived", $time, mirror.awaited.size());
    end

    $display("Covered %0d lookups and %0d ticks: %0d hits, %0d fills (%0d wide), %0d fallbacks.",
             mirror.lookups, mirror.ticks, mirror.hits, mirror.fills, mirror.wide_fills,
             mirror.fallbacks);
    $display("Idling phases: none, idle sender, stalling receiver, both; %0d mismatches.",
             mirror.errors);
    if (mirror.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
